[rtl/itpm_pkg.sv]
package itpm_pkg;

    // Loop and angle constants. Angles are in 1/256 degree, but QUARTER_Z is in 1/65536 degree.
    localparam int SETTLE_SAMPLES = 50;
    localparam int CORDIC_STEPS   = 16;
    localparam int HALF_TURN      = 46080;
    localparam int FULL_TURN      = 92160;
    localparam int INC_DIVISOR    = 16000;
    localparam int INC_BIAS       = 8000;
    localparam int QUARTER_Z      = 90 * 65536;

    // Inverse CORDIC gain, Q30.
    localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;

    // Configuration register indexes.
    localparam logic [7:0] REG_GYRO_SMOOTH_GAIN = 8'd0;
    localparam logic [7:0] REG_BLEND_GAIN       = 8'd1;
    localparam logic [7:0] REG_ANGLE_DEADZONE   = 8'd2;
    localparam logic [7:0] REG_GAIN_X           = 8'd3;
    localparam logic [7:0] REG_GAIN_Y           = 8'd4;
    localparam logic [7:0] REG_GAIN_Z           = 8'd5;
    localparam logic [7:0] REG_LIMIT_XY         = 8'd6;
    localparam logic [7:0] REG_LIMIT_Z          = 8'd7;

    // Arctangent of 2^-i in 1/65536 degree.
    function automatic logic [22:0] atan_entry(input logic [4:0] i);
        logic [22:0] v;
        case (i)
            5'd0:    v = 23'd2949120;
            5'd1:    v = 23'd1740967;
            5'd2:    v = 23'd919879;
            5'd3:    v = 23'd466945;
            5'd4:    v = 23'd234379;
            5'd5:    v = 23'd117304;
            5'd6:    v = 23'd58666;
            5'd7:    v = 23'd29335;
            5'd8:    v = 23'd14668;
            5'd9:    v = 23'd7334;
            5'd10:   v = 23'd3667;
            5'd11:   v = 23'd1833;
            5'd12:   v = 23'd917;
            5'd13:   v = 23'd458;
            5'd14:   v = 23'd229;
            5'd15:   v = 23'd115;
            5'd16:   v = 23'd57;
            5'd17:   v = 23'd29;
            5'd18:   v = 23'd14;
            5'd19:   v = 23'd7;
            5'd20:   v = 23'd4;
            5'd21:   v = 23'd2;
            5'd22:   v = 23'd1;
            default: v = 23'd0;
        endcase
        return v;
    endfunction

endpackage

[rtl/imu_tilt_to_position_mapper_core.sv]
// Tilt-to-position mapper. One inertial sample enters per transfer on the
// slave stream and yields exactly one position transfer on the master stream.
// The block low-pass filters the three gyro rates, blends gyro-integrated roll
// and pitch with accelerometer roll and pitch (vectoring CORDIC), integrates
// and wraps yaw, captures an origin after the settle count or on recenter, and
// maps the wrapped origin deltas through a deadzone, a signed gain and a clamp.
// All arithmetic is serial: a shift-add multiplier retiring one multiplier bit
// per cycle, a restoring divider retiring one quotient bit per cycle, and a
// CORDIC stage doing one rotation per cycle. From acceptance to result a sample
// passes three rate channels (a load, the smoothing multiply, a store, the
// time-step multiply, a load, the division and a store), a first CORDIC pass
// (setup, 16 rotations, a gain correction and a store), a second pass without
// the gain correction, two blends, one step each for yaw and the origin, three
// delta channels (a load, the wrap division, a load, the gain multiply and a
// store) and a step to load the output register. The sequencer holds one
// sample at a time; a finished sample waits until the output register is free,
// and a new sample can be taken in the cycle after the previous one has moved
// into the output register, even if that result is still waiting to be taken
// downstream. Configuration writes complete at once and should be issued only
// while no sample is in flight.
module imu_tilt_to_position_mapper_core
    import itpm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // accel_x[15:0], accel_y[31:16], accel_z[47:32], rate_x[65:48],
    // rate_y[83:66], rate_z[101:84], elapsed_ms[117:102], zero pad
    input  logic [119:0] s_axis_tdata,
    // recenter
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // pos_x[15:0], pos_y[31:16], pos_z[47:32]
    output logic [47:0]  m_axis_tdata,
    // origin_ready
    output logic         m_axis_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE, S_SM_LD, S_SM_MUL, S_SM_END, S_INC_MUL, S_INC_LD, S_INC_DIV,
        S_INC_END, S_CR_INIT, S_CR_ITER, S_CR_MAG, S_CR_END, S_BL_LD,
        S_BL_MUL, S_BL_END, S_YAW, S_ORG, S_DL_LD, S_DL_DIV, S_DL_END,
        S_MAP_MUL, S_MAP_END, S_DONE
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [15:0]        g_reg, b_reg, dz_reg;
    logic signed [15:0] gx_reg, gy_reg, gz_reg;
    logic [14:0]        lxy_reg, lz_reg;

    // Captured sample.
    logic signed [15:0] ax_reg, ay_reg, az_reg;
    logic signed [17:0] rate_reg [3];
    logic [5:0]         ms_reg;
    logic               rc_reg;

    // Filter state. Axis order is roll, pitch, yaw.
    logic signed [23:0] s_reg [3];
    logic signed [16:0] inc_reg [3];
    logic signed [23:0] roll_reg, pitch_reg, yaw_reg;
    logic signed [23:0] org_reg [3];
    logic               ov_reg;
    logic [7:0]         cnt_reg;

    logic [1:0]         k_reg;
    logic               pass_reg;

    // Shift-add multiplier: acc += a*wa + b*wb, one bit of wa and wb a cycle.
    logic signed [43:0] acc_reg, ma_reg, mb_reg;
    logic [15:0]        wa_reg;
    logic [16:0]        wb_reg;
    logic [4:0]         mcnt_reg;

    // Restoring divider on a magnitude, quotient shifts into num_reg.
    logic [29:0]        num_reg;
    logic [17:0]        rem_reg;
    logic [4:0]         dcnt_reg;
    logic               div_full_reg;
    logic               neg_reg;
    logic signed [25:0] v_reg;

    // CORDIC.
    logic signed [31:0] x_reg, y_reg, mag_reg;
    logic signed [25:0] z_reg;
    logic [4:0]         ci_reg;
    logic               zero_reg;
    logic [32:0]        macc_reg;
    logic signed [17:0] roll_acc_reg, pitch_acc_reg;

    logic signed [15:0] pos_reg [3];

    logic               out_valid_reg;
    logic [47:0]        out_data_reg;
    logic               out_user_reg;

    // Combinational helpers.
    logic signed [43:0] mul_add, sm_round, inc_v, inc_abs, bl_round, map_p, map_round;
    logic signed [23:0] sm_new, bl_clamp;
    logic [17:0]        div_dsr, rem_sh;
    logic               div_ge;
    logic signed [31:0] xs, ys, cin_x, cin_y;
    logic signed [25:0] atn, ang_fin;
    logic signed [17:0] ang_r;
    logic [32:0]        macc_sum;
    logic signed [23:0] ang_sel;
    logic signed [25:0] dl_v, dl_abs, yaw_sum, yaw_wrap;
    logic signed [18:0] wr_r, wr_w, wr_abs, dl_d;
    logic signed [15:0] gain_sel;
    logic [14:0]        lim_sel;
    logic [16:0]        gain_abs;
    logic signed [15:0] map_pos;
    logic [7:0]         cnt_new;
    logic signed [16:0] inc_new;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    always_comb
    begin
        mul_add = (wa_reg[0] ? ma_reg : 44'sd0) + (wb_reg[0] ? mb_reg : 44'sd0);
        sm_round = (acc_reg + 44'sd32768) >>> 16;
        sm_new = sm_round[23:0];
        inc_v = acc_reg + 44'(INC_BIAS);
        inc_abs = (inc_v < 0) ? -inc_v : inc_v;

        div_dsr = div_full_reg ? 18'(FULL_TURN) : 18'(INC_DIVISOR);
        rem_sh = {rem_reg[16:0], num_reg[29]};
        div_ge = (rem_sh >= div_dsr);
        inc_new = neg_reg ? -(17'(num_reg) + 17'(rem_reg != 18'd0)) : 17'(num_reg);

        cin_x = pass_reg ? mag_reg : (32'(az_reg) <<< 12);
        cin_y = pass_reg ? -(32'(ax_reg) <<< 12) : (32'(ay_reg) <<< 12);
        xs = x_reg >>> ci_reg;
        ys = y_reg >>> ci_reg;
        atn = 26'(atan_entry(ci_reg));
        macc_sum = macc_reg + (INV_GAIN_Q30[ci_reg] ? {2'b00, x_reg[30:0]} : 33'd0);
        ang_fin = zero_reg ? 26'sd0 : ((z_reg + 26'sd128) >>> 8);
        ang_r = ang_fin[17:0];

        bl_round = (acc_reg + 44'sd32768) >>> 16;
        if (bl_round > 44'sd8388607)
            bl_clamp = 24'sh7FFFFF;
        else if (bl_round < -44'sd8388608)
            bl_clamp = 24'sh800000;
        else
            bl_clamp = bl_round[23:0];

        yaw_sum = 26'(yaw_reg) + 26'(inc_reg[2]);
        if (yaw_sum > 26'(HALF_TURN))
            yaw_wrap = yaw_sum - 26'(FULL_TURN);
        else if (yaw_sum < -26'(HALF_TURN))
            yaw_wrap = yaw_sum + 26'(FULL_TURN);
        else
            yaw_wrap = yaw_sum;

        case (k_reg)
            2'd0:
            begin
                ang_sel = roll_reg;
                gain_sel = gz_reg;
                lim_sel = lz_reg;
            end
            2'd1:
            begin
                ang_sel = pitch_reg;
                gain_sel = gy_reg;
                lim_sel = lxy_reg;
            end
            default:
            begin
                ang_sel = yaw_reg;
                gain_sel = gx_reg;
                lim_sel = lxy_reg;
            end
        endcase
        dl_v = 26'(ang_sel) - 26'(org_reg[k_reg]);
        dl_abs = (dl_v < 0) ? -dl_v : dl_v;
        gain_abs = (gain_sel < 0) ? 17'(-18'(gain_sel)) : 17'(gain_sel);

        // Wrap the delta back into a half turn either side of zero.
        if (neg_reg)
            wr_r = (rem_reg == 18'd0) ? 19'sd0 : 19'(FULL_TURN) - 19'(rem_reg);
        else
            wr_r = 19'(rem_reg);
        if (v_reg <= 26'(HALF_TURN) && v_reg >= -26'(HALF_TURN))
            wr_w = 19'(v_reg);
        else if (!neg_reg)
            wr_w = (wr_r > 19'(HALF_TURN)) ? wr_r - 19'(FULL_TURN) : wr_r;
        else
            wr_w = (wr_r >= 19'(HALF_TURN)) ? wr_r - 19'(FULL_TURN) : wr_r;
        wr_abs = (wr_w < 0) ? -wr_w : wr_w;
        dl_d = (wr_abs < 19'(dz_reg)) ? 19'sd0 : wr_w;

        map_p = (gain_sel < 0) ? -acc_reg : acc_reg;
        map_round = (map_p + 44'sd2048) >>> 12;
        if (map_round > 44'(signed'({1'b0, lim_sel})))
            map_pos = 16'(lim_sel);
        else if (map_round < -44'(signed'({1'b0, lim_sel})))
            map_pos = -16'(lim_sel);
        else
            map_pos = map_round[15:0];

        cnt_new = (cnt_reg < 8'd255) ? cnt_reg + 8'd1 : cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            g_reg <= 16'd58982;
            b_reg <= 16'd64225;
            dz_reg <= 16'd256;
            gx_reg <= -16'sd1280;
            gy_reg <= 16'sd0;
            gz_reg <= 16'sd1280;
            lxy_reg <= 15'd20800;
            lz_reg <= 15'd24000;
            for (int i = 0; i < 3; i++)
            begin
                s_reg[i] <= '0;
                org_reg[i] <= '0;
                inc_reg[i] <= '0;
                rate_reg[i] <= '0;
                pos_reg[i] <= '0;
            end
            ax_reg <= '0;
            ay_reg <= '0;
            az_reg <= '0;
            ms_reg <= '0;
            rc_reg <= 1'b0;
            roll_reg <= '0;
            pitch_reg <= '0;
            yaw_reg <= '0;
            ov_reg <= 1'b0;
            cnt_reg <= '0;
            k_reg <= '0;
            pass_reg <= 1'b0;
            acc_reg <= '0;
            ma_reg <= '0;
            mb_reg <= '0;
            wa_reg <= '0;
            wb_reg <= '0;
            mcnt_reg <= '0;
            num_reg <= '0;
            rem_reg <= '0;
            dcnt_reg <= '0;
            div_full_reg <= 1'b0;
            neg_reg <= 1'b0;
            v_reg <= '0;
            x_reg <= '0;
            y_reg <= '0;
            z_reg <= '0;
            mag_reg <= '0;
            ci_reg <= '0;
            zero_reg <= 1'b0;
            macc_reg <= '0;
            roll_acc_reg <= '0;
            pitch_acc_reg <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg <= '0;
            out_user_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_GYRO_SMOOTH_GAIN: g_reg <= cfg_data;
                    REG_BLEND_GAIN:       b_reg <= cfg_data;
                    REG_ANGLE_DEADZONE:   dz_reg <= cfg_data;
                    REG_GAIN_X:           gx_reg <= cfg_data;
                    REG_GAIN_Y:           gy_reg <= cfg_data;
                    REG_GAIN_Z:           gz_reg <= cfg_data;
                    REG_LIMIT_XY:         lxy_reg <= cfg_data[14:0];
                    REG_LIMIT_Z:          lz_reg <= cfg_data[14:0];
                    default:              ;
                endcase
            end

            if (out_valid_reg && m_axis_tready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        ax_reg <= s_axis_tdata[15:0];
                        ay_reg <= s_axis_tdata[31:16];
                        az_reg <= s_axis_tdata[47:32];
                        rate_reg[0] <= s_axis_tdata[65:48];
                        rate_reg[1] <= s_axis_tdata[83:66];
                        rate_reg[2] <= s_axis_tdata[101:84];
                        // A missing or implausible time step counts as 20 ms.
                        if (s_axis_tdata[117:102] == 16'd0 || s_axis_tdata[117:102] > 16'd50)
                            ms_reg <= 6'd20;
                        else
                            ms_reg <= s_axis_tdata[107:102];
                        rc_reg <= s_axis_tuser;
                        k_reg <= 2'd0;
                        state_reg <= S_SM_LD;
                    end
                end
                S_SM_LD:
                begin
                    acc_reg <= '0;
                    ma_reg <= 44'(s_reg[k_reg]);
                    mb_reg <= 44'(rate_reg[k_reg]) <<< 6;
                    wa_reg <= g_reg;
                    wb_reg <= 17'd65536 - 17'(g_reg);
                    mcnt_reg <= '0;
                    state_reg <= S_SM_MUL;
                end
                S_SM_MUL, S_INC_MUL, S_BL_MUL, S_MAP_MUL:
                begin
                    acc_reg <= acc_reg + mul_add;
                    ma_reg <= ma_reg <<< 1;
                    mb_reg <= mb_reg <<< 1;
                    wa_reg <= wa_reg >> 1;
                    wb_reg <= wb_reg >> 1;
                    mcnt_reg <= mcnt_reg + 5'd1;
                    if (mcnt_reg == 5'd16)
                    begin
                        case (state_reg)
                            S_SM_MUL:  state_reg <= S_SM_END;
                            S_INC_MUL: state_reg <= S_INC_LD;
                            S_BL_MUL:  state_reg <= S_BL_END;
                            default:   state_reg <= S_MAP_END;
                        endcase
                    end
                end
                S_SM_END:
                begin
                    s_reg[k_reg] <= sm_new;
                    acc_reg <= '0;
                    ma_reg <= 44'(sm_new);
                    mb_reg <= '0;
                    wa_reg <= 16'(ms_reg);
                    wb_reg <= '0;
                    mcnt_reg <= '0;
                    state_reg <= S_INC_MUL;
                end
                S_INC_LD:
                begin
                    num_reg <= inc_abs[29:0];
                    neg_reg <= (inc_v < 0);
                    rem_reg <= '0;
                    dcnt_reg <= '0;
                    div_full_reg <= 1'b0;
                    state_reg <= S_INC_DIV;
                end
                S_INC_DIV, S_DL_DIV:
                begin
                    rem_reg <= div_ge ? rem_sh - div_dsr : rem_sh;
                    num_reg <= {num_reg[28:0], div_ge};
                    dcnt_reg <= dcnt_reg + 5'd1;
                    if (dcnt_reg == 5'd29)
                        state_reg <= (state_reg == S_INC_DIV) ? S_INC_END : S_DL_END;
                end
                S_INC_END:
                begin
                    inc_reg[k_reg] <= inc_new;
                    if (k_reg == 2'd2)
                    begin
                        pass_reg <= 1'b0;
                        state_reg <= S_CR_INIT;
                    end
                    else
                    begin
                        k_reg <= k_reg + 2'd1;
                        state_reg <= S_SM_LD;
                    end
                end
                S_CR_INIT:
                begin
                    zero_reg <= (cin_x == 0) && (cin_y == 0);
                    // Vectors in the left half plane are turned by a quarter turn first.
                    if (cin_x < 0)
                    begin
                        if (cin_y >= 0)
                        begin
                            x_reg <= cin_y;
                            y_reg <= -cin_x;
                            z_reg <= 26'(QUARTER_Z);
                        end
                        else
                        begin
                            x_reg <= -cin_y;
                            y_reg <= cin_x;
                            z_reg <= -26'(QUARTER_Z);
                        end
                    end
                    else
                    begin
                        x_reg <= cin_x;
                        y_reg <= cin_y;
                        z_reg <= '0;
                    end
                    ci_reg <= '0;
                    state_reg <= S_CR_ITER;
                end
                S_CR_ITER:
                begin
                    if (y_reg >= 0)
                    begin
                        x_reg <= x_reg + ys;
                        y_reg <= y_reg - xs;
                        z_reg <= z_reg + atn;
                    end
                    else
                    begin
                        x_reg <= x_reg - ys;
                        y_reg <= y_reg + xs;
                        z_reg <= z_reg - atn;
                    end
                    ci_reg <= ci_reg + 5'd1;
                    if (ci_reg == 5'(CORDIC_STEPS - 1))
                    begin
                        ci_reg <= '0;
                        macc_reg <= '0;
                        state_reg <= pass_reg ? S_CR_END : S_CR_MAG;
                    end
                end
                S_CR_MAG:
                begin
                    macc_reg <= macc_sum >> 1;
                    ci_reg <= ci_reg + 5'd1;
                    if (ci_reg == 5'd29)
                        state_reg <= S_CR_END;
                end
                S_CR_END:
                begin
                    if (!pass_reg)
                    begin
                        roll_acc_reg <= ang_r;
                        mag_reg <= macc_reg[31:0];
                        pass_reg <= 1'b1;
                        state_reg <= S_CR_INIT;
                    end
                    else
                    begin
                        pitch_acc_reg <= ang_r;
                        k_reg <= 2'd0;
                        state_reg <= S_BL_LD;
                    end
                end
                S_BL_LD:
                begin
                    acc_reg <= '0;
                    ma_reg <= 44'(ang_sel) + 44'(inc_reg[k_reg]);
                    mb_reg <= (k_reg == 2'd0) ? 44'(roll_acc_reg) : 44'(pitch_acc_reg);
                    wa_reg <= b_reg;
                    wb_reg <= 17'd65536 - 17'(b_reg);
                    mcnt_reg <= '0;
                    state_reg <= S_BL_MUL;
                end
                S_BL_END:
                begin
                    if (k_reg == 2'd0)
                    begin
                        roll_reg <= bl_clamp;
                        k_reg <= 2'd1;
                        state_reg <= S_BL_LD;
                    end
                    else
                    begin
                        pitch_reg <= bl_clamp;
                        state_reg <= S_YAW;
                    end
                end
                S_YAW:
                begin
                    yaw_reg <= yaw_wrap[23:0];
                    state_reg <= S_ORG;
                end
                S_ORG:
                begin
                    if (!ov_reg)
                    begin
                        cnt_reg <= cnt_new;
                        if (cnt_new >= 8'(SETTLE_SAMPLES))
                        begin
                            ov_reg <= 1'b1;
                            org_reg[0] <= roll_reg;
                            org_reg[1] <= pitch_reg;
                            org_reg[2] <= yaw_reg;
                        end
                    end
                    if (rc_reg)
                    begin
                        ov_reg <= 1'b1;
                        org_reg[0] <= roll_reg;
                        org_reg[1] <= pitch_reg;
                        org_reg[2] <= yaw_reg;
                    end
                    k_reg <= 2'd0;
                    state_reg <= S_DL_LD;
                end
                S_DL_LD:
                begin
                    v_reg <= dl_v;
                    neg_reg <= (dl_v < 0);
                    num_reg <= 30'(unsigned'(dl_abs));
                    rem_reg <= '0;
                    dcnt_reg <= '0;
                    div_full_reg <= 1'b1;
                    state_reg <= S_DL_DIV;
                end
                S_DL_END:
                begin
                    acc_reg <= '0;
                    ma_reg <= '0;
                    mb_reg <= 44'(dl_d);
                    wa_reg <= '0;
                    wb_reg <= gain_abs;
                    mcnt_reg <= '0;
                    state_reg <= S_MAP_MUL;
                end
                S_MAP_END:
                begin
                    pos_reg[k_reg] <= map_pos;
                    if (k_reg == 2'd2)
                        state_reg <= S_DONE;
                    else
                    begin
                        k_reg <= k_reg + 2'd1;
                        state_reg <= S_DL_LD;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg <= {pos_reg[0], pos_reg[1], pos_reg[2]};
                        out_user_reg <= ov_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // Once an origin exists it is never dropped.
    origin_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |=> ov_reg)
        else $error("origin flag cleared");

    // Yaw always stays within a half turn either side of zero.
    yaw_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (yaw_reg <= 24'(HALF_TURN)) && (yaw_reg >= -24'(HALF_TURN)))
        else $error("yaw out of range");

    // A result appears only from the final sequencer step.
    result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result without finished sample");

endmodule

[tb/testbench.sv]
module testbench;
    import itpm_pkg::*;

    // One inertial sample and one position result, at the block's widths.
    typedef struct {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic signed [17:0] rx;
        logic signed [17:0] ry;
        logic signed [17:0] rz;
        logic [15:0]        ms;
        logic               recenter;
    } sample_t;

    typedef struct {
        logic [15:0] px;
        logic [15:0] py;
        logic [15:0] pz;
        logic        ready;
    } position_t;

    // Arctangent of 2^-i in 1/65536 degree, for the predictor's CORDIC.
    localparam longint ATAN_DEG16 [0:15] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115
    };
    localparam longint INV_GAIN     = 652032874;
    localparam longint ANGLE_MAX    = 8388607;
    localparam longint ANGLE_MIN    = -8388608;
    localparam longint CYCLE_LIMIT  = 2000000;
    localparam int     HOLD_CYCLES  = 3000;
    localparam int     DRAIN_CYCLES = 40;
    localparam int     END_CYCLES   = 600;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [119:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [47:0]  m_axis_tdata;
    logic         m_axis_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [7:0]   cfg_index;
    logic [15:0]  cfg_data;

    imu_tilt_to_position_mapper_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Predictor copy of the configuration registers.
    longint smooth_gain_q16;
    longint blend_gain_q16;
    longint deadzone;
    longint gain_yaw_x;
    longint gain_pitch_y;
    longint gain_roll_z;
    longint limit_xy_mm16;
    longint limit_z_mm16;

    // Predictor copy of the filter and origin state.
    longint filtered_rate [3];
    longint roll_pos;
    longint pitch_pos;
    longint yaw_pos;
    longint origin_pos [3];
    bit     have_origin;
    int     settle_samples_seen;

    position_t expected_positions [$];
    int        fail_count;
    int        samples_sent;
    int        positions_checked;
    longint    cycle_count;
    bit        hold_request;
    int        burst_left;

    // Clock and the run limit.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count = cycle_count + 1;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("imu_tilt_to_position_mapper_core test failed");
                $finish;
            end
        end
    end

    // Rounding to nearest with halves toward +inf, as floor(v / 2^s + 1/2).
    function automatic longint round_shift(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp_range(input longint v, input longint lo,
                                           input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Wraps an angle into +-180 degrees; the side it came from decides
    // whether exactly 180 degrees comes out positive or negative.
    function automatic longint wrap_half_turn(input longint v);
        longint r;
        if (v <= HALF_TURN && v >= -HALF_TURN)
            return v;
        r = v % FULL_TURN;
        if (r < 0)
            r += FULL_TURN;
        if (v > HALF_TURN)
        begin
            if (r > HALF_TURN)
                r -= FULL_TURN;
        end
        else if (r >= HALF_TURN)
        begin
            r -= FULL_TURN;
        end
        return r;
    endfunction

    // Vectoring CORDIC: angle of (x, y) in 1/65536 degree and the
    // gain-corrected magnitude. A vector in the left half plane is first
    // turned by a quarter turn so the loop always starts with x >= 0.
    task automatic cordic_angle(input longint x_in, input longint y_in,
                                output longint magnitude, output longint angle);
        longint x;
        longint y;
        longint z;
        longint t;
        longint xs;
        longint ys;
        x = x_in;
        y = y_in;
        z = 0;
        if (x == 0 && y == 0)
        begin
            magnitude = 0;
            angle = 0;
            return;
        end
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                z = QUARTER_Z;
            end
            else
            begin
                x = -y;
                y = t;
                z = -QUARTER_Z;
            end
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x += ys;
                y -= xs;
                z += ATAN_DEG16[i];
            end
            else
            begin
                x -= ys;
                y += xs;
                z -= ATAN_DEG16[i];
            end
        end
        magnitude = (x * INV_GAIN) >>> 30;
        angle = z;
    endtask

    function automatic longint apply_deadzone(input longint v);
        longint a;
        a = (v < 0) ? -v : v;
        return (a < deadzone) ? 0 : v;
    endfunction

    function automatic logic [15:0] scale_and_clamp(input longint delta, input longint gain,
                                                     input longint lim);
        longint p;
        p = clamp_range(round_shift(delta * gain, 12), -lim, lim);
        return p[15:0];
    endfunction

    // Advances the predicted filter state by one sample and returns the
    // position that the block must produce for it.
    task automatic advance_tilt_filter(input sample_t s, output position_t pos);
        longint step_ms;
        longint rate_in [3];
        longint increment [3];
        longint biased;
        longint magnitude;
        longint angle;
        longint unused_mag;
        longint roll_accel;
        longint pitch_accel;
        longint d_roll;
        longint d_pitch;
        longint d_yaw;
        step_ms = longint'(s.ms);
        if (step_ms == 0 || step_ms > 50)
            step_ms = 20;
        rate_in[0] = longint'(s.rx) * 64;
        rate_in[1] = longint'(s.ry) * 64;
        rate_in[2] = longint'(s.rz) * 64;
        for (int k = 0; k < 3; k++)
        begin
            filtered_rate[k] = round_shift(smooth_gain_q16 * filtered_rate[k]
                                           + (65536 - smooth_gain_q16) * rate_in[k], 16);
            // Rounded division by the ms-to-second divisor, halves up.
            biased = filtered_rate[k] * step_ms + INC_BIAS;
            increment[k] = (biased - (((biased % INC_DIVISOR) + INC_DIVISOR) % INC_DIVISOR))
                           / INC_DIVISOR;
        end
        cordic_angle(longint'(s.az) * 4096, longint'(s.ay) * 4096, magnitude, angle);
        roll_accel = round_shift(angle, 8);
        cordic_angle(magnitude, -longint'(s.ax) * 4096, unused_mag, angle);
        pitch_accel = round_shift(angle, 8);

        roll_pos = clamp_range(round_shift(blend_gain_q16 * (roll_pos + increment[0])
                               + (65536 - blend_gain_q16) * roll_accel, 16),
                               ANGLE_MIN, ANGLE_MAX);
        pitch_pos = clamp_range(round_shift(blend_gain_q16 * (pitch_pos + increment[1])
                                + (65536 - blend_gain_q16) * pitch_accel, 16),
                                ANGLE_MIN, ANGLE_MAX);
        yaw_pos = wrap_half_turn(yaw_pos + increment[2]);

        // The settle count runs only while no origin exists and captures
        // the origin when it reaches the limit; recenter captures on any
        // sample.
        if (!have_origin)
        begin
            if (settle_samples_seen < 255)
                settle_samples_seen++;
            if (settle_samples_seen >= SETTLE_SAMPLES)
            begin
                have_origin = 1'b1;
                origin_pos[0] = roll_pos;
                origin_pos[1] = pitch_pos;
                origin_pos[2] = yaw_pos;
            end
        end
        if (s.recenter)
        begin
            origin_pos[0] = roll_pos;
            origin_pos[1] = pitch_pos;
            origin_pos[2] = yaw_pos;
            have_origin = 1'b1;
        end

        d_roll  = apply_deadzone(wrap_half_turn(roll_pos - origin_pos[0]));
        d_pitch = apply_deadzone(wrap_half_turn(pitch_pos - origin_pos[1]));
        d_yaw   = apply_deadzone(wrap_half_turn(yaw_pos - origin_pos[2]));
        pos.px = scale_and_clamp(d_yaw, gain_yaw_x, limit_xy_mm16);
        pos.py = scale_and_clamp(d_pitch, gain_pitch_y, limit_xy_mm16);
        pos.pz = scale_and_clamp(d_roll, gain_roll_z, limit_z_mm16);
        pos.ready = have_origin;
    endtask

    // Sends one sample; valid stays high so a following call can stream on.
    task automatic send_sample(input sample_t s);
        position_t pos;
        s_axis_tdata <= {2'b00, s.ms, s.rz, s.ry, s.rx, s.az, s.ay, s.ax};
        s_axis_tuser <= s.recenter;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        advance_tilt_filter(s, pos);
        expected_positions.push_back(pos);
        samples_sent++;
    endtask

    // Bursts of random length separated by random gaps.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 7);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_positions.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes one register; valid is lowered by the caller after the batch.
    task automatic write_register(input logic [7:0] index, input logic [15:0] value);
        cfg_index <= index;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        case (index)
            REG_GYRO_SMOOTH_GAIN: smooth_gain_q16 = longint'(value);
            REG_BLEND_GAIN:       blend_gain_q16 = longint'(value);
            REG_ANGLE_DEADZONE:   deadzone = longint'(value);
            REG_GAIN_X:           gain_yaw_x = longint'(signed'(value));
            REG_GAIN_Y:           gain_pitch_y = longint'(signed'(value));
            REG_GAIN_Z:           gain_roll_z = longint'(signed'(value));
            REG_LIMIT_XY:         limit_xy_mm16 = longint'(value[14:0]);
            REG_LIMIT_Z:          limit_z_mm16 = longint'(value[14:0]);
            default: ;
        endcase
    endtask

    task automatic write_all_registers(input logic [15:0] smooth, input logic [15:0] blend,
                                       input logic [15:0] dz, input logic [15:0] gx,
                                       input logic [15:0] gy, input logic [15:0] gz,
                                       input logic [15:0] lxy, input logic [15:0] lz);
        wait_drained();
        write_register(REG_GYRO_SMOOTH_GAIN, smooth);
        write_register(REG_BLEND_GAIN, blend);
        write_register(REG_ANGLE_DEADZONE, dz);
        write_register(REG_GAIN_X, gx);
        write_register(REG_GAIN_Y, gy);
        write_register(REG_GAIN_Z, gz);
        write_register(REG_LIMIT_XY, lxy);
        write_register(REG_LIMIT_Z, lz);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Random sample: mostly a plausible gravity vector with noise and
    // moderate rates, sometimes anything the fields allow.
    function automatic sample_t random_sample(input bit allow_recenter);
        sample_t s;
        if ($urandom_range(0, 3) == 0)
        begin
            s.ax = 16'($urandom);
            s.ay = 16'($urandom);
            s.az = 16'($urandom);
            s.rx = 18'($urandom);
            s.ry = 18'($urandom);
            s.rz = 18'($urandom);
        end
        else
        begin
            s.ax = 16'($signed($urandom_range(0, 8000)) - 4000);
            s.ay = 16'($signed($urandom_range(0, 8000)) - 4000);
            s.az = 16'(16384 + $signed($urandom_range(0, 4000)) - 2000);
            s.rx = 18'($signed($urandom_range(0, 20000)) - 10000);
            s.ry = 18'($signed($urandom_range(0, 20000)) - 10000);
            s.rz = 18'($signed($urandom_range(0, 40000)) - 20000);
        end
        case ($urandom_range(0, 9))
            0:       s.ms = 16'd0;
            1:       s.ms = 16'($urandom);
            2:       s.ms = 16'($urandom_range(51, 60));
            default: s.ms = 16'($urandom_range(1, 50));
        endcase
        s.recenter = allow_recenter && ($urandom_range(0, 15) == 0);
        return s;
    endfunction

    function automatic sample_t make_sample(input int ax, input int ay, input int az,
                                            input int rx, input int ry, input int rz,
                                            input int ms, input bit rc);
        sample_t s;
        s.ax = 16'(ax);
        s.ay = 16'(ay);
        s.az = 16'(az);
        s.rx = 18'(rx);
        s.ry = 18'(ry);
        s.rz = 18'(rz);
        s.ms = 16'(ms);
        s.recenter = rc;
        return s;
    endfunction

    task automatic send_random(input int count, input bit allow_recenter);
        for (int i = 0; i < count; i++)
        begin
            send_sample(random_sample(allow_recenter));
            pace_sender();
        end
    endtask

    // Field extremes, bad time steps, a zero accelerometer vector and a
    // vector pointing straight along negative z, all before any origin.
    task automatic test_directed_extremes();
        send_sample(make_sample(0, 0, 0, 0, 0, 0, 20, 1'b0));
        send_sample(make_sample(0, 0, -16384, 0, 0, 0, 0, 1'b0));
        send_sample(make_sample(0, 0, -1, 0, 0, 0, 51, 1'b0));
        send_sample(make_sample(32767, 32767, 32767, 131071, 131071, 131071, 50, 1'b0));
        send_sample(make_sample(-32768, -32768, -32768, -131072, -131072, -131072, 1, 1'b0));
        send_sample(make_sample(-32768, 0, 0, 131071, -131072, 131071, 65535, 1'b0));
        send_sample(make_sample(32767, -32768, 0, -131072, 131071, -131072, 50, 1'b0));
        send_sample(make_sample(0, 32767, -32768, -1, 1, -1, 0, 1'b0));
        send_sample(make_sample(0, -32768, -32768, 1, -1, 1, 32768, 1'b0));
        for (int i = 0; i < 8; i++)
            send_sample(make_sample(0, 0, 16384, 0, 0, 131071, 50, 1'b0));
    endtask

    // No recenter until the settle count has captured the origin.
    task automatic test_settle_capture();
        send_random(SETTLE_SAMPLES, 1'b0);
    endtask

    task automatic test_recenter();
        send_sample(make_sample(100, -200, 16000, 500, -500, 3000, 20, 1'b1));
        send_sample(make_sample(0, 0, 0, 0, 0, 131071, 50, 1'b1));
        send_sample(make_sample(-32768, 32767, -32768, -131072, 131071, -131072, 0, 1'b1));
        send_random(10, 1'b1);
    endtask

    // Extreme register settings, writes to indexes past the list, and a
    // deadzone so large that every delta short of a full half turn is zeroed.
    task automatic test_register_extremes();
        write_all_registers(16'd0, 16'd0, 16'd0, 16'h8000, 16'h7FFF, 16'h8000,
                            16'd32767, 16'd0);
        send_random(40, 1'b1);
        write_all_registers(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF,
                            16'd0, 16'd32767);
        write_register(REG_LIMIT_Z + 8'd1, 16'h1234);
        write_register(8'hFF, 16'hFFFF);
        cfg_valid <= 1'b0;
        send_random(30, 1'b1);
        write_all_registers(16'd0, 16'd0, 16'd46080, 16'h7FFF, 16'h8000, 16'h7FFF,
                            16'd32767, 16'd32767);
        send_random(20, 1'b1);
    endtask

    // Blend weight at its top and steady full-scale rates drive roll and
    // pitch into 24-bit saturation while yaw keeps wrapping.
    task automatic test_runaway_angles();
        write_all_registers(16'd0, 16'hFFFF, 16'd0, 16'd300, 16'hFF00, 16'd1,
                            16'd32767, 16'd32767);
        for (int i = 0; i < 330; i++)
        begin
            send_sample(make_sample($urandom, $urandom, $urandom,
                                    131071 - $urandom_range(0, 15),
                                    -131072 + $urandom_range(0, 15),
                                    $urandom, 50, 1'b0));
            pace_sender();
        end
    endtask

    // The receiver holds off for a long stretch while samples keep coming.
    task automatic test_output_backpressure();
        wait_drained();
        hold_request = 1'b1;
        for (int i = 0; i < 6; i++)
            send_sample(random_sample(1'b1));
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 4; phase++)
        begin
            write_all_registers(16'($urandom), 16'($urandom), 16'($urandom_range(0, 2048)),
                                16'($urandom), 16'($urandom), 16'($urandom),
                                16'($urandom_range(0, 32767)),
                                16'($urandom_range(0, 32767)));
            send_random(50, 1'b1);
        end
        write_all_registers(16'd58982, 16'd64225, 16'd256, 16'hFB00, 16'd0, 16'd1280,
                            16'd20800, 16'd24000);
        send_random(40, 1'b1);
    endtask

    // Receiver: changes its stall pattern at random intervals, and
    // honors a request for one long hold-off.
    initial
    begin
        int mode;
        int mode_left;
        int hold_left;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                check_position();
            if (hold_request && hold_left == 0)
            begin
                hold_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(64, 512);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (mode == 0)
                m_axis_tready <= 1'b1;
            else if (mode == 1)
                m_axis_tready <= ($urandom_range(0, 3) != 0);
            else
                m_axis_tready <= ($urandom_range(0, 3) == 0);
        end
    end

    task automatic check_position();
        position_t exp_pos;
        if (expected_positions.size() == 0)
        begin
            $error("position transfer with no sample outstanding: data %h", m_axis_tdata);
            fail_count++;
            return;
        end
        exp_pos = expected_positions.pop_front();
        positions_checked++;
        if (m_axis_tdata[15:0] !== exp_pos.px)
        begin
            $error("pos_x expected %0d got %0d", $signed(exp_pos.px),
                   $signed(m_axis_tdata[15:0]));
            fail_count++;
        end
        if (m_axis_tdata[31:16] !== exp_pos.py)
        begin
            $error("pos_y expected %0d got %0d", $signed(exp_pos.py),
                   $signed(m_axis_tdata[31:16]));
            fail_count++;
        end
        if (m_axis_tdata[47:32] !== exp_pos.pz)
        begin
            $error("pos_z expected %0d got %0d", $signed(exp_pos.pz),
                   $signed(m_axis_tdata[47:32]));
            fail_count++;
        end
        if (m_axis_tuser !== exp_pos.ready)
        begin
            $error("origin_ready expected %0b got %0b", exp_pos.ready, m_axis_tuser);
            fail_count++;
        end
    endtask

    // Main sequence.
    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        hold_request = 1'b0;
        burst_left = 0;
        fail_count = 0;
        samples_sent = 0;
        positions_checked = 0;
        smooth_gain_q16 = 58982;
        blend_gain_q16 = 64225;
        deadzone = 256;
        gain_yaw_x = -1280;
        gain_pitch_y = 0;
        gain_roll_z = 1280;
        limit_xy_mm16 = 20800;
        limit_z_mm16 = 24000;
        for (int k = 0; k < 3; k++)
        begin
            filtered_rate[k] = 0;
            origin_pos[k] = 0;
        end
        roll_pos = 0;
        pitch_pos = 0;
        yaw_pos = 0;
        have_origin = 1'b0;
        settle_samples_seen = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_extremes();
        test_settle_capture();
        test_recenter();
        test_output_backpressure();
        test_register_extremes();
        test_runaway_angles();
        test_random_settings();

        wait_drained();
        repeat (END_CYCLES) @(posedge clk);
        $display("Checked %0d positions for %0d samples over %0d cycles:", positions_checked,
                 samples_sent, cycle_count);
        $display("field extremes, settle and recenter origins, register extremes, backpressure.");
        if (fail_count == 0 && expected_positions.size() == 0)
            $display("imu_tilt_to_position_mapper_core test passed");
        else
            $display("imu_tilt_to_position_mapper_core test failed");
        $finish;
    end

endmodule
